@@ hw/rtl/msw_pkg.sv @@
// shared types, constants and helpers for the mate search window calculator
`timescale 1ns / 1ps
`default_nettype none

package msw_pkg;

  // reference coordinate width, valid from 16 to 40
  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned CFG_BITS   = 24;
  localparam int unsigned OUT_BITS   = 32;
  localparam int unsigned IN_BITS    = 32;
  localparam int unsigned RL_BITS    = 16;

  // arithmetic width: room for coordinate plus config offsets and a sign
  localparam int unsigned AW = ((COORD_BITS > OUT_BITS) ? COORD_BITS : OUT_BITS) + 2;

  localparam logic [IN_BITS-1:0] IN_MASK = (COORD_BITS >= IN_BITS) ? {IN_BITS{1'b1}} :
                                           IN_BITS'((65'd1 << COORD_BITS) - 65'd1);
  localparam logic signed [AW-1:0] COORD_MAX = AW'((65'd1 << COORD_BITS) - 65'd1);

  localparam int unsigned IN_TDATA_W  = 120;
  localparam int unsigned OUT_TDATA_W = 136;

  // register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAGMENT_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_WINDOW      = 2'd2;

  localparam logic [CFG_BITS-1:0] RST_FRAGMENT_LENGTH = 24'd300;
  localparam logic [CFG_BITS-1:0] RST_CLOSE_WINDOW    = 24'd2000;
  localparam logic [CFG_BITS-1:0] RST_FAR_WINDOW      = 24'd100000;

  typedef struct packed {
    logic [CFG_BITS-1:0] fragment_length;
    logic [CFG_BITS-1:0] close_window;
    logic [CFG_BITS-1:0] far_window;
  } cfg_t;

  typedef struct packed {
    logic               direction;
    logic [IN_BITS-1:0] anchor_start;
    logic [IN_BITS-1:0] anchor_end;
    logic [RL_BITS-1:0] read_length;
    logic [IN_BITS-1:0] chrom_length;
  } item_t;

  typedef struct packed {
    logic                window_ok;
    logic [OUT_BITS-1:0] close_begin;
    logic [OUT_BITS-1:0] close_end;
    logic [OUT_BITS-1:0] far_begin;
    logic [OUT_BITS-1:0] far_end;
  } res_t;

  // input coordinate reduced modulo 2^COORD_BITS, widened to the arithmetic width
  function automatic logic signed [AW-1:0] coord_to_aw(input logic [IN_BITS-1:0] x);
    return $signed(AW'(x & IN_MASK));
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/msw_cfg_regs.sv @@
// configuration registers: fragment length, close and far window lengths
`timescale 1ns / 1ps
`default_nettype none

module msw_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [msw_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  wire logic [msw_pkg::CFG_BITS-1:0]   cfg_wdata_i,
  output msw_pkg::cfg_t                       cfg_o
);
  import msw_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_FRAGMENT_LENGTH: cfg_d.fragment_length = cfg_wdata_i;
        REG_CLOSE_WINDOW:    cfg_d.close_window    = cfg_wdata_i;
        REG_FAR_WINDOW:      cfg_d.far_window      = cfg_wdata_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fragment_length <= RST_FRAGMENT_LENGTH;
      cfg_q.close_window    <= RST_CLOSE_WINDOW;
      cfg_q.far_window      <= RST_FAR_WINDOW;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/msw_calc.sv @@
// window arithmetic: close and far windows for one anchored read
`timescale 1ns / 1ps
`default_nettype none

module msw_calc (
  input  wire msw_pkg::item_t item_i,
  input  wire msw_pkg::cfg_t  cfg_i,
  output msw_pkg::res_t       res_o
);
  import msw_pkg::*;

  localparam logic signed [AW-1:0] ONE  = AW'(1);
  localparam logic signed [AW-1:0] ZERO = '0;

  logic signed [AW-1:0] start, aend, len, rl, frag, cw, half, fw;
  logic signed [AW-1:0] cb_dn, ce_raw_dn, ce_dn, fe_raw_dn, fe_dn;
  logic signed [AW-1:0] u_up, ce_up, ce1_up, cb_up, fb_up;
  logic                 fail_dn, fail_up, cw_zero;
  logic signed [AW-1:0] cb, ce, fb, fe;
  logic                 ok;

  always_comb begin
    start   = coord_to_aw(item_i.anchor_start);
    aend    = coord_to_aw(item_i.anchor_end);
    len     = coord_to_aw(item_i.chrom_length);
    rl      = $signed(AW'(item_i.read_length));
    frag    = $signed(AW'(cfg_i.fragment_length));
    cw      = $signed(AW'(cfg_i.close_window));
    half    = $signed(AW'(cfg_i.close_window[CFG_BITS-1:1]));
    // zero far window acts as a one-base window
    fw      = (cfg_i.far_window == '0) ? ONE : $signed(AW'(cfg_i.far_window));
    cw_zero = (cfg_i.close_window == '0);

    // downstream: windows begin at anchor end + 1 + fragment - half close window, ends clipped at chromosome end
    cb_dn     = aend + ONE + frag - half;
    ce_raw_dn = cb_dn + cw - ONE;
    ce_dn     = (ce_raw_dn >= len) ? len - ONE : ce_raw_dn;
    fe_raw_dn = cb_dn + fw - ONE;
    fe_dn     = (fe_raw_dn >= len) ? len - ONE : fe_raw_dn;
    fail_dn   = (cb_dn < ZERO) || (cb_dn >= len) || cw_zero ||
                ((ce_dn - cb_dn + ONE) < rl);

    // upstream: windows end at anchor start plus half the close window minus one minus fragment length, clipped at zero
    u_up    = start + half;
    ce_up   = u_up - ONE - frag;
    ce1_up  = u_up - frag;
    cb_up   = (ce1_up >= cw) ? ce1_up - cw : ZERO;
    fb_up   = (ce1_up >= fw) ? ce1_up - fw : ZERO;
    fail_up = (u_up <= (ONE + frag)) || cw_zero || (ce_up > COORD_MAX) || (ce1_up < rl);

    if (item_i.direction) begin
      ok = !fail_up;
      cb = cb_up;
      ce = ce_up;
      fb = fb_up;
      fe = ce_up;
    end else begin
      ok = !fail_dn;
      cb = cb_dn;
      ce = ce_dn;
      fb = cb_dn;
      fe = fe_dn;
    end

    res_o.window_ok   = ok;
    res_o.close_begin = ok ? cb[OUT_BITS-1:0] : '0;
    res_o.close_end   = ok ? ce[OUT_BITS-1:0] : '0;
    res_o.far_begin   = ok ? fb[OUT_BITS-1:0] : '0;
    res_o.far_end     = ok ? fe[OUT_BITS-1:0] : '0;
  end

endmodule

`default_nettype wire

@@ hw/rtl/mate_search_window_calc.sv @@
// top level of the mate search window calculator
//
//  port group      dir   role
//  s_axis_*        in    anchored read transfers (direction, coordinates, lengths)
//  m_axis_*        out   search window transfers (ok flag, close and far windows)
//  cfg_*           in    register writes: fragment length, close window, far window
//
//  an input transfer passes the input register, window arithmetic and the result
//  register in that order; one read is taken every cycle when the output flows
//  a stalled output holds its result while the input register still takes one read
//  reset clears both stage valids and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none

module mate_search_window_calc (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // [0] direction, [32:1] anchor_start, [64:33] anchor_end,
  // [80:65] read_length, [112:81] chrom_length, [119:113] zero
  input  wire logic [msw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [0] window_ok, [32:1] close_begin, [64:33] close_end,
  // [96:65] far_begin, [128:97] far_end, [135:129] zero
  output logic [msw_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic                              cfg_we_i,
  input  wire logic [msw_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  wire logic [msw_pkg::CFG_BITS-1:0]      cfg_wdata_i
);
  import msw_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  item_t in_q;
  logic  in_vld_q, in_vld_d;
  res_t  calc_res;
  res_t  out_q;
  logic  out_vld_q, out_vld_d;
  logic  out_adv, in_take;

  msw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  always_comb begin
    in_item.direction    = s_axis_tdata[0];
    in_item.anchor_start = s_axis_tdata[32:1];
    in_item.anchor_end   = s_axis_tdata[64:33];
    in_item.read_length  = s_axis_tdata[80:65];
    in_item.chrom_length = s_axis_tdata[112:81];
  end

  // result register can load when empty or being drained
  assign out_adv       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || out_adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign in_vld_d  = in_take || (in_vld_q && !out_adv);
  assign out_vld_d = out_adv ? in_vld_q : out_vld_q;

  msw_calc u_calc (
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (calc_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item;
    end
    if (out_adv && in_vld_q) begin
      out_q <= calc_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q.far_end, out_q.far_begin, out_q.close_end,
                          out_q.close_begin, out_q.window_ok};

  // failed windows carry all-zero regions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.window_ok) |->
      (out_q.close_begin == '0 && out_q.close_end == '0 &&
       out_q.far_begin == '0 && out_q.far_end == '0))
    else $error("failed result with nonzero window");

  // a result appears only after an item sat in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(in_vld_q))
    else $error("result without input item");

  // input register fills only from an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_vld_q) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("input stage filled without transfer");

  // an item blocked by a stalled output is kept unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_adv) |=> (in_vld_q && $stable(in_q)))
    else $error("blocked item lost or overwritten");

endmodule

`default_nettype wire

@@ tb/mate_search_window_calc_tb.sv @@
// testbench for the mate search window calculator: directed table, then random reads per setting
`timescale 1ns / 1ps

module mate_search_window_calc_tb;
  import msw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_READS  = 1100;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned MAX_PRINTS  = 40;

  localparam logic DIR_DOWN = 1'b0;
  localparam logic DIR_UP   = 1'b1;

  // unmapped register index, a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam res_t WIN_FAIL = '0;

  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_BITS-1:0]  reg_val;
    item_t                rd;
    bit                   known;
    res_t                 want;
  } plan_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr_i    = '0;
  logic [CFG_BITS-1:0]    cfg_wdata_i   = '0;

  // register copy used for prediction
  logic [CFG_BITS-1:0] frag_len  = RST_FRAGMENT_LENGTH;
  logic [CFG_BITS-1:0] close_len = RST_CLOSE_WINDOW;
  logic [CFG_BITS-1:0] far_len   = RST_FAR_WINDOW;

  res_t        window_q[$];
  plan_row_t   plan_q[$];
  int unsigned err_count = 0;
  int unsigned cycle_cnt = 0;

  // travel with the read on the input side, so the monitor knows a typed-in window
  bit   tx_known = 1'b0;
  res_t tx_want  = '0;

  bit          tx_steady   = 1'b0;
  bit          rx_steady   = 1'b0;
  bit          rx_hold_req = 1'b0;
  int unsigned rx_wait     = 0;

  item_t seen_rd;
  res_t  got_win;
  res_t  want_win;

  mate_search_window_calc uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // exact window arithmetic in 64 bits, then the low 32 bits of each coordinate
  function automatic res_t predict_windows(input item_t rd);
    longint cmask, s, ae, rl, len, frag, cw, fw, u, cb, ce, fb, fe;
    res_t   r;
    cmask = longint'((65'd1 << COORD_BITS) - 65'd1);
    s     = {32'd0, rd.anchor_start} & cmask;
    ae    = {32'd0, rd.anchor_end} & cmask;
    len   = {32'd0, rd.chrom_length} & cmask;
    rl    = {48'd0, rd.read_length};
    frag  = {40'd0, frag_len};
    cw    = {40'd0, close_len};
    fw    = (far_len == '0) ? 64'sd1 : {40'd0, far_len};
    if (rd.direction == DIR_DOWN) begin
      cb = ae + 1 + frag - cw / 2;
      if (cb < 0 || cb >= len || cw == 0) return WIN_FAIL;
      ce = cb + cw - 1;
      if (ce >= len) ce = len - 1;
      if (ce - cb + 1 < rl) return WIN_FAIL;
      fb = cb;
      fe = fb + fw - 1;
      if (fe >= len) fe = len - 1;
    end else begin
      u = s + cw / 2;
      if (u <= 1 + frag || cw == 0) return WIN_FAIL;
      ce = u - 1 - frag;
      if (ce > cmask || ce + 1 < rl) return WIN_FAIL;
      fe = ce;
      cb = (ce + 1 >= cw) ? ce + 1 - cw : 0;
      fb = (fe + 1 >= fw) ? fe + 1 - fw : 0;
    end
    r.window_ok   = 1'b1;
    r.close_begin = cb[31:0];
    r.close_end   = ce[31:0];
    r.far_begin   = fb[31:0];
    r.far_end     = fe[31:0];
    return r;
  endfunction

  function automatic res_t win(input logic [31:0] cb, input logic [31:0] ce,
                               input logic [31:0] fb, input logic [31:0] fe);
    res_t r;
    r.window_ok   = 1'b1;
    r.close_begin = cb;
    r.close_end   = ce;
    r.far_begin   = fb;
    r.far_end     = fe;
    return r;
  endfunction

  function automatic void plan_read(input bit known, input res_t want, input logic dir,
                                    input logic [31:0] s, input logic [31:0] e,
                                    input logic [15:0] rl, input logic [31:0] len);
    plan_row_t row;
    row.is_write        = 1'b0;
    row.reg_idx         = '0;
    row.reg_val         = '0;
    row.rd.direction    = dir;
    row.rd.anchor_start = s;
    row.rd.anchor_end   = e;
    row.rd.read_length  = rl;
    row.rd.chrom_length = len;
    row.known           = known;
    row.want            = want;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_BITS-1:0] val);
    plan_row_t row;
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.reg_val  = val;
    row.rd       = '0;
    row.known    = 1'b0;
    row.want     = '0;
    plan_q.push_back(row);
  endfunction

  // mostly reads placed near the window thresholds, some with every field random
  function automatic item_t random_read();
    item_t       rd;
    logic [31:0] base;
    logic [31:0] off;
    rd.direction    = 1'($urandom_range(0, 1));
    rd.chrom_length = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 5000000);
    case ($urandom_range(0, 3))
      0: rd.read_length = 16'($urandom);
      1: rd.read_length = 16'(close_len) + 16'($urandom_range(0, 2)) - 16'd1;
      default: rd.read_length = 16'($urandom_range(0, 400));
    endcase
    off = $urandom_range(0, 300);
    case ($urandom_range(0, 7))
      0: begin
        rd.anchor_start = $urandom;
        rd.anchor_end   = $urandom;
        rd.read_length  = 16'($urandom);
        rd.chrom_length = $urandom;
        return rd;
      end
      1: base = $urandom_range(0, 3000);
      2: base = rd.chrom_length - $urandom_range(0, 3000);
      3: base = $urandom_range(0, rd.chrom_length);
      4: base = 32'hFFFF_FFFF - $urandom_range(0, 20000000);
      5: begin
        // start that puts the upstream end around zero, or the downstream start around zero
        if (rd.direction == DIR_UP)
          base = 32'(frag_len) + 1 - 32'(close_len / 2) + $urandom_range(0, 4) - 2;
        else
          base = 32'(close_len / 2) - 1 - 32'(frag_len) + $urandom_range(0, 4) - 2 - off;
      end
      default: begin
        // downstream start right at the chromosome end
        base = rd.chrom_length - 1 - 32'(frag_len) + 32'(close_len / 2)
               + $urandom_range(0, 4) - 2 - off;
      end
    endcase
    rd.anchor_start = base;
    rd.anchor_end   = base + off;
    return rd;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic send_read(input item_t rd, input bit known, input res_t want);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {7'd0, rd.chrom_length, rd.read_length, rd.anchor_end,
                      rd.anchor_start, rd.direction};
    s_axis_tvalid <= 1'b1;
    tx_known      <= known;
    tx_want       <= want;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_windows();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (window_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_FRAGMENT_LENGTH: frag_len  = val;
      REG_CLOSE_WINDOW:    close_len = val;
      REG_FAR_WINDOW:      far_len   = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // result side: random stall per transfer, plus one long hold on request
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) rx_wait = rx_steady ? 0 : $urandom_range(0, 9);
    else if (rx_wait != 0) rx_wait--;
    if (rx_hold_req) begin
      rx_wait     = HOLD_CYCLES;
      rx_hold_req = 1'b0;
    end
    m_axis_tready <= (rx_wait == 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        seen_rd.direction    = s_axis_tdata[0];
        seen_rd.anchor_start = s_axis_tdata[32:1];
        seen_rd.anchor_end   = s_axis_tdata[64:33];
        seen_rd.read_length  = s_axis_tdata[80:65];
        seen_rd.chrom_length = s_axis_tdata[112:81];
        window_q.push_back(tx_known ? tx_want : predict_windows(seen_rd));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_win.window_ok   = m_axis_tdata[0];
        got_win.close_begin = m_axis_tdata[32:1];
        got_win.close_end   = m_axis_tdata[64:33];
        got_win.far_begin   = m_axis_tdata[96:65];
        got_win.far_end     = m_axis_tdata[128:97];
        if (window_q.size() == 0) begin
          report_mismatch("window with no read pending", got_win.close_begin, '0);
        end else begin
          want_win = window_q.pop_front();
          if (got_win.window_ok !== want_win.window_ok)
            report_mismatch("window_ok", 32'(got_win.window_ok), 32'(want_win.window_ok));
          if (got_win.close_begin !== want_win.close_begin)
            report_mismatch("close_begin", got_win.close_begin, want_win.close_begin);
          if (got_win.close_end !== want_win.close_end)
            report_mismatch("close_end", got_win.close_end, want_win.close_end);
          if (got_win.far_begin !== want_win.far_begin)
            report_mismatch("far_begin", got_win.far_begin, want_win.far_begin);
          if (got_win.far_end !== want_win.far_end)
            report_mismatch("far_end", got_win.far_end, want_win.far_end);
        end
      end
    end
  end

  initial begin
    plan_row_t           row;
    logic [CFG_BITS-1:0] f, c, w;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults: fragment 300, close 2000, far 100000
    plan_read(1, win(401, 2400, 401, 100400), DIR_DOWN, 1000, 1100, 100, 1000000);
    plan_read(1, WIN_FAIL, DIR_DOWN, 0, 0, 0, 1000000);            // start below zero
    plan_read(1, WIN_FAIL, DIR_DOWN, 5000, 5000, 0, 0);            // empty chromosome
    plan_read(1, win(301, 1999, 301, 1999), DIR_DOWN, 900, 1000, 100, 2000);
    plan_read(1, WIN_FAIL, DIR_DOWN, 900, 1000, 16'hFFFF, 2000);   // window too small
    plan_read(0, WIN_FAIL, DIR_DOWN, '1, '1, 0, '1);
    plan_read(1, WIN_FAIL, DIR_DOWN, '1, '1, 0, 32'h1000);         // start past the end
    plan_read(1, win(3700, 5699, 0, 5699), DIR_UP, 5000, 5100, 100, 10000);
    plan_read(1, WIN_FAIL, DIR_UP, '1, '1, 16'hFFFF, '1);          // end past the top
    plan_read(1, win(0, 699, 0, 699), DIR_UP, 0, 0, 0, 0);
    plan_read(1, win(198700, 200699, 100700, 200699), DIR_UP, 200000, 200100, 0, 300000);

    plan_write(REG_FRAGMENT_LENGTH, '1);
    plan_read(1, WIN_FAIL, DIR_UP, 100, 200, 0, 1000);             // upstream end below zero
    plan_read(1, WIN_FAIL, DIR_DOWN, 0, 0, 0, 1000);
    plan_read(0, WIN_FAIL, DIR_DOWN, 0, 0, 0, '1);

    plan_write(REG_CLOSE_WINDOW, '0);                              // empty close window
    plan_read(1, WIN_FAIL, DIR_DOWN, 5000, 5000, 0, 100000000);
    plan_read(1, WIN_FAIL, DIR_UP, 32'h8000_0000, 32'h8000_0000, 0, '1);

    plan_write(REG_CLOSE_WINDOW, '1);
    plan_write(REG_FAR_WINDOW, '0);                                // empty far window
    plan_write(REG_FRAGMENT_LENGTH, '0);
    plan_read(1, WIN_FAIL, DIR_DOWN, 100, 100, 0, '1);
    plan_read(0, WIN_FAIL, DIR_DOWN, 10000000, 10000000, 16'hFFFF, '1);
    plan_read(0, WIN_FAIL, DIR_UP, 0, 0, 0, 0);
    plan_write(REG_SPARE, '1);
    plan_read(0, WIN_FAIL, DIR_DOWN, 10000000, 10000000, 16'hFFFF, '1);

    plan_write(REG_FAR_WINDOW, '1);
    plan_write(REG_CLOSE_WINDOW, 24'd1);
    plan_read(1, WIN_FAIL, DIR_DOWN, 0, 0, 0, 1);
    plan_read(0, WIN_FAIL, DIR_DOWN, 0, 0, 1, 2);
    plan_read(1, WIN_FAIL, DIR_DOWN, 0, 0, 2, 2);
    plan_read(1, WIN_FAIL, DIR_UP, 0, 0, 0, 0);
    plan_read(0, WIN_FAIL, DIR_UP, 2, 2, 2, 0);

    foreach (plan_q[i]) begin
      row = plan_q[i];
      if (row.is_write) begin
        drain_windows();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_read(row.rd, row.known, row.want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_windows();
      case (p)
        0: begin f = RST_FRAGMENT_LENGTH; c = RST_CLOSE_WINDOW; w = RST_FAR_WINDOW; end
        1: begin f = '0; c = '0; w = '0; end
        2: begin f = '1; c = '1; w = '1; end
        3: begin f = '0; c = 24'd1; w = '1; end
        4: begin f = '1; c = 24'd1; w = '0; end
        5: begin
          f = 24'($urandom_range(0, 1000));
          c = 24'($urandom_range(1, 5000));
          w = 24'($urandom_range(0, 200000));
        end
        6: begin f = 24'($urandom); c = 24'($urandom); w = 24'($urandom); end
        default: begin f = 24'd500; c = 24'd400; w = 24'd300; end
      endcase
      write_reg(REG_FRAGMENT_LENGTH, f);
      write_reg(REG_CLOSE_WINDOW, c);
      write_reg(REG_FAR_WINDOW, w);
      tx_steady = (p == 0 || p == 2 || p == 4);
      rx_steady = (p == 0 || p == 5);
      // long hold while reads keep coming, so the pipeline backs up into the input
      if (p == 2) rx_hold_req = 1'b1;
      repeat (RAND_READS / NUM_PHASES) send_read(random_read(), 1'b0, WIN_FAIL);
    end
    drain_windows();

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
